### hdl/dlsb_pkg.sv
`default_nettype none
package dlsb_pkg;
   localparam int MaxLayers = 16;
   localparam int IdxBits   = 4;
   localparam int CntBits   = 5;
   localparam int PicBits   = 8;

   typedef enum logic [3:0] {
      CMD_TICK    = 4'd0,
      CMD_INSERT  = 4'd1,
      CMD_DELETE  = 4'd2,
      CMD_UP      = 4'd3,
      CMD_DOWN    = 4'd4,
      CMD_CLEAR   = 4'd5,
      CMD_BLON    = 4'd6,
      CMD_BLOFF   = 4'd7,
      CMD_ALLOFF  = 4'd8,
      CMD_WMSET   = 4'd9,
      CMD_WMRST   = 4'd10,
      CMD_SCAN    = 4'd11,
      CMD_NEXT    = 4'd12,
      CMD_RESTART = 4'd13
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_FINISH,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [PicBits-1:0] pic;
      logic [15:0]        period;
      logic [15:0]        countdown;
      logic               visible;
      logic               handler;
   } layer_type;
endpackage
`default_nettype wire

### hdl/dlsb_tick_unit.sv
`default_nettype none
module dlsb_tick_unit (
   input  dlsb_pkg::layer_type lay_i,
   output dlsb_pkg::layer_type lay_o,
   output logic                fire_o,
   output logic                toggle_o
);
   import dlsb_pkg::*;
   logic [15:0] dec;
   logic        hit;
   always_comb begin
      dec      = lay_i.countdown - 16'd1;
      hit      = (lay_i.period != 16'd0) && (dec == 16'd0);
      lay_o    = lay_i;
      fire_o   = 1'b0;
      toggle_o = 1'b0;
      if (lay_i.period != 16'd0) begin
         lay_o.countdown = hit ? lay_i.period : dec;
         if (hit) begin
            if (lay_i.handler) begin
               fire_o = 1'b1;
            end else begin
               lay_o.visible = ~lay_i.visible;
               toggle_o      = 1'b1;
            end
         end
      end
   end
endmodule
`default_nettype wire

### hdl/display_layer_stack_with_blink_core.sv
// Walking commands (tick, insert, delete, all off, searches, next) visit one layer
// a cycle. A new request is taken only once the response beat has left, so a
// command is finished before the next one is accepted. A sequencer plus one
// shared layer update unit do the work.
// Reset: synchronous, active high; clears count, cursor, watermark and control.
// Layer contents are undefined until written.
`default_nettype none
module display_layer_stack_with_blink_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // command[3:0], position[8:4], pic_id[16:9], period[32:17], has_blink_handler[33]
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0], layer_count[6:2], scan_pic_id[14:7], scan_done[15],
   // handler_mask[31:16], structure_changed[32]
   output logic [39:0]      rsp_tdata
);
   import dlsb_pkg::*;

   state_type            state_ff, state_in;
   layer_type            mem_ff [MaxLayers];
   logic [CntBits-1:0]   cnt_ff, cnt_in, cur_ff, cur_in, wm_ff, wm_in;
   logic [CntBits-1:0]   i_ff, i_in;
   logic [3:0]           cmd_ff;
   logic [CntBits-1:0]   pos_ff;
   logic [PicBits-1:0]   pic_ff;
   logic [15:0]          per_ff;
   logic                 hnd_ff;
   logic [1:0]           st_ff, st_in;
   logic [PicBits-1:0]   spic_ff, spic_in;
   logic                 sdone_ff, sdone_in, chg_ff, chg_in;
   logic [15:0]          hm_ff, hm_in;
   logic                 we;
   logic [IdxBits-1:0]   wa;
   layer_type            wd, rd, tk;
   layer_type            swap_ff, swap_in;
   logic                 fire, tog;
   logic [CntBits-1:0]   pos_c;
   logic [CntBits-1:0]   ip1;
   logic [CntBits-1:0]   lo;

   dlsb_tick_unit u_tick (.lay_i(rd), .lay_o(tk), .fire_o(fire), .toggle_o(tog));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {7'd0, chg_ff, hm_ff, sdone_ff, spic_ff, cnt_ff, st_ff};
   assign rd  = mem_ff[i_ff[IdxBits-1:0]];
   assign ip1 = i_ff + 5'd1;
   assign pos_c = (pos_ff > cnt_ff) ? cnt_ff : pos_ff;
   assign lo  = (cmd_ff == CMD_UP) ? pos_ff : pos_ff - 5'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         cur_ff   <= '0;
         wm_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         cur_ff   <= cur_in;
         wm_ff    <= wm_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      st_ff    <= st_in;
      spic_ff  <= spic_in;
      sdone_ff <= sdone_in;
      chg_ff   <= chg_in;
      hm_ff    <= hm_in;
      swap_ff  <= swap_in;
      if (req_tvalid && req_tready) begin
         cmd_ff <= req_tdata[3:0];
         pos_ff <= req_tdata[8:4];
         pic_ff <= req_tdata[16:9];
         per_ff <= req_tdata[32:17];
         hnd_ff <= req_tdata[33];
      end
      if (we) mem_ff[wa] <= wd;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff; cur_in = cur_ff; wm_in = wm_ff; i_in = i_ff;
      st_in = st_ff; spic_in = spic_ff; sdone_in = sdone_ff;
      chg_in = chg_ff; hm_in = hm_ff; swap_in = swap_ff;
      we = 1'b0; wa = i_ff[IdxBits-1:0]; wd = rd;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               st_in = ST_OK; spic_in = '0; sdone_in = 1'b0;
               chg_in = 1'b0; hm_in = '0;
               state_in = S_WALK;
               case (cmd_type'(req_tdata[3:0]))
                  CMD_INSERT: i_in = cnt_ff;
                  CMD_DELETE: i_in = req_tdata[8:4];
                  CMD_NEXT:   i_in = cur_ff;
                  default:    i_in = '0;
               endcase
            end
         end
         S_WALK: begin
            case (cmd_type'(cmd_ff))
               CMD_TICK: begin
                  if (i_ff >= cnt_ff) state_in = S_OUT;
                  else begin
                     we = 1'b1; wd = tk;
                     if (fire) hm_in[i_ff[IdxBits-1:0]] = 1'b1;
                     if (tog) chg_in = 1'b1;
                     i_in = ip1;
                  end
               end
               CMD_INSERT: begin
                  if (cnt_ff == 5'(MaxLayers)) begin
                     st_in = ST_FULL; state_in = S_OUT;
                  end else if (i_ff > pos_c) begin
                     we = 1'b1; wd = mem_ff[4'(i_ff - 5'd1)];
                     i_in = i_ff - 5'd1;
                  end else begin
                     we = 1'b1;
                     wd = '{pic: pic_ff, period: per_ff, countdown: per_ff,
                            visible: 1'b1, handler: hnd_ff};
                     cnt_in = cnt_ff + 5'd1; chg_in = 1'b1; state_in = S_OUT;
                  end
               end
               CMD_DELETE: begin
                  if (pos_ff >= cnt_ff) begin
                     st_in = ST_NOTFOUND; state_in = S_OUT;
                  end else if (ip1 < cnt_ff) begin
                     we = 1'b1; wd = mem_ff[ip1[IdxBits-1:0]]; i_in = ip1;
                  end else begin
                     cnt_in = cnt_ff - 5'd1; chg_in = 1'b1; state_in = S_OUT;
                  end
               end
               CMD_UP, CMD_DOWN: begin
                  if ((cmd_ff == CMD_UP && (pos_ff + 5'd1 >= cnt_ff || pos_ff == 5'd31))
                      || (cmd_ff == CMD_DOWN && (pos_ff == 5'd0 || pos_ff >= cnt_ff))) begin
                     st_in = ST_NOTFOUND; state_in = S_OUT;
                  end else begin
                     we = 1'b1; wa = lo[IdxBits-1:0]; wd = mem_ff[4'(lo + 5'd1)];
                     swap_in = mem_ff[lo[IdxBits-1:0]];
                     i_in = lo;
                     state_in = S_FINISH;
                  end
               end
               CMD_CLEAR: begin
                  cnt_in = '0; chg_in = 1'b1; state_in = S_OUT;
               end
               CMD_BLON, CMD_BLOFF, CMD_RESTART: begin
                  if (i_ff >= cnt_ff) begin
                     st_in = ST_NOTFOUND; state_in = S_OUT;
                  end else if (rd.pic == pic_ff) begin
                     we = 1'b1; state_in = S_OUT;
                     if (cmd_ff == CMD_BLON) begin
                        wd.period = per_ff; wd.countdown = per_ff;
                        wd.visible = 1'b0; chg_in = 1'b1;
                     end else if (cmd_ff == CMD_BLOFF) begin
                        wd.period = '0; wd.visible = 1'b1; chg_in = 1'b1;
                     end else begin
                        wd.countdown = rd.period;
                     end
                  end else i_in = ip1;
               end
               CMD_ALLOFF: begin
                  chg_in = 1'b1;
                  if (i_ff >= cnt_ff) state_in = S_OUT;
                  else begin
                     we = 1'b1; wd.period = '0; wd.visible = 1'b1; i_in = ip1;
                  end
               end
               CMD_WMSET: begin wm_in = cnt_ff; state_in = S_OUT; end
               CMD_WMRST: begin wm_in = '0; state_in = S_OUT; end
               CMD_SCAN:  begin cur_in = wm_ff; state_in = S_OUT; end
               CMD_NEXT: begin
                  if (i_ff >= cnt_ff) begin
                     sdone_in = 1'b1; cur_in = i_ff; state_in = S_OUT;
                  end else if (rd.visible) begin
                     spic_in = rd.pic; cur_in = ip1; state_in = S_OUT;
                  end else i_in = ip1;
               end
               default: state_in = S_OUT;
            endcase
         end
         S_FINISH: begin
            we = 1'b1; wa = ip1[IdxBits-1:0]; wd = swap_ff;
            state_in = S_OUT; chg_in = 1'b1;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire
